FILE: design/vlbr_pkg.sv
// shared types and constants for the variable-length bit reader
package vlbr_pkg;

  localparam int unsigned OpW    = 3;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 32;
  localparam int unsigned AddrW  = 24;
  localparam int unsigned PosW   = 5;
  localparam int unsigned SliceW = 16;

  // auto-advance flag in the control byte
  localparam int unsigned AutoBit = 7;
  // positions stay at or below this; crossing it moves the pointer on
  localparam logic [PosW-1:0]  PosLimit = 5'd16;
  localparam logic [AddrW-1:0] PtrStep  = 24'd2;

  typedef enum logic [OpW-1:0] {
    OP_CTRL     = 3'd0,
    OP_ADDR_LO  = 3'd1,
    OP_ADDR_MID = 3'd2,
    OP_ADDR_HI  = 3'd3,
    OP_READ_LO  = 3'd4,
    OP_READ_HI  = 3'd5
  } vlbr_op_e;

  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [ByteW-1:0] write_data;
    logic [WordW-1:0] memory_word;
  } req_t;

  typedef struct packed {
    logic [ByteW-1:0] read_data;
    logic [AddrW-1:0] fetch_address_a;
    logic [AddrW-1:0] fetch_address_b;
  } res_t;

endpackage

FILE: design/vlbr_req_if.sv
// request channel: access code, write byte and fetched memory word
interface vlbr_req_if;
  import vlbr_pkg::*;

  logic             valid;
  logic             ready;
  logic [OpW-1:0]   opcode;
  logic [ByteW-1:0] write_data;
  logic [WordW-1:0] memory_word;

  modport source (output valid, output opcode, output write_data, output memory_word,
                  input ready);
  modport sink   (input valid, input opcode, input write_data, input memory_word,
                  output ready);
endinterface

FILE: design/vlbr_res_if.sv
// result channel: read byte and both fetch pointers
interface vlbr_res_if;
  import vlbr_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] read_data;
  logic [AddrW-1:0] fetch_address_a;
  logic [AddrW-1:0] fetch_address_b;

  modport source (output valid, output read_data, output fetch_address_a,
                  output fetch_address_b, input ready);
  modport sink   (input valid, input read_data, input fetch_address_a,
                  input fetch_address_b, output ready);
endinterface

FILE: design/vlbr_core.sv
// reader state (width, flag, positions, pointers) and the per-request step logic
module vlbr_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          commit_i,
  input  vlbr_pkg::req_t req_i,
  output vlbr_pkg::res_t res_o
);
  import vlbr_pkg::*;

  logic             auto_q, auto_d;
  logic [PosW-1:0]  width_q, width_d;
  logic [PosW-1:0]  pos_a_q, pos_a_d;
  logic [PosW-1:0]  pos_b_q, pos_b_d;
  logic [AddrW-1:0] ptr_a_q, ptr_a_d;
  logic [AddrW-1:0] ptr_b_q, ptr_b_d;

  logic [PosW-1:0]   shamt;
  logic [SliceW-1:0] slice;
  logic [PosW-1:0]   new_width;
  logic [ByteW-1:0]  rd;
  logic [PosW:0]     sum_a, sum_b;
  logic              wrap_a, wrap_b;
  logic [PosW-1:0]   adv_pos_a, adv_pos_b;
  logic [AddrW-1:0]  adv_ptr_a, adv_ptr_b;

  // both read kinds use position b as the shift
  assign shamt = (pos_b_q > PosLimit) ? PosLimit : pos_b_q;
  assign slice = SliceW'(req_i.memory_word >> shamt);

  assign new_width = (req_i.write_data[3:0] == 4'd0) ? PosLimit
                                                      : {1'b0, req_i.write_data[3:0]};

  assign sum_a     = {1'b0, pos_a_q} + {1'b0, width_q};
  assign wrap_a    = sum_a > {1'b0, PosLimit};
  assign adv_pos_a = wrap_a ? PosW'(sum_a - {1'b0, PosLimit}) : PosW'(sum_a);
  assign adv_ptr_a = wrap_a ? ptr_a_q + PtrStep : ptr_a_q;

  assign sum_b     = {1'b0, pos_b_q} + {1'b0, width_q};
  assign wrap_b    = sum_b > {1'b0, PosLimit};
  assign adv_pos_b = wrap_b ? PosW'(sum_b - {1'b0, PosLimit}) : PosW'(sum_b);
  assign adv_ptr_b = wrap_b ? ptr_b_q + PtrStep : ptr_b_q;

  always_comb begin
    auto_d  = auto_q;
    width_d = width_q;
    pos_a_d = pos_a_q;
    pos_b_d = pos_b_q;
    ptr_a_d = ptr_a_q;
    ptr_b_d = ptr_b_q;
    rd      = '0;
    unique case (req_i.opcode)
      OP_CTRL: begin
        auto_d  = req_i.write_data[AutoBit];
        width_d = new_width;
        if (req_i.write_data[AutoBit]) begin
          pos_a_d = new_width;
          pos_b_d = new_width;
        end
      end
      OP_ADDR_LO: begin
        ptr_a_d[7:0]   = req_i.write_data;
        ptr_b_d[7:0]   = req_i.write_data;
        pos_a_d        = '0;
        pos_b_d        = '0;
      end
      OP_ADDR_MID: begin
        ptr_a_d[15:8]  = req_i.write_data;
        ptr_b_d[15:8]  = req_i.write_data;
        pos_a_d        = '0;
        pos_b_d        = '0;
      end
      OP_ADDR_HI: begin
        ptr_a_d[23:16] = req_i.write_data;
        ptr_b_d[23:16] = req_i.write_data;
        pos_a_d        = '0;
        pos_b_d        = '0;
      end
      OP_READ_LO: begin
        rd = slice[7:0];
        if (auto_q) begin
          pos_a_d = adv_pos_a;
          ptr_a_d = adv_ptr_a;
        end
      end
      OP_READ_HI: begin
        rd = slice[15:8];
        if (auto_q) begin
          pos_b_d = adv_pos_b;
          ptr_b_d = adv_ptr_b;
        end
      end
      default: begin
        rd = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_q  <= 1'b0;
      width_q <= '0;
      pos_a_q <= '0;
      pos_b_q <= '0;
      ptr_a_q <= '0;
      ptr_b_q <= '0;
    end else if (commit_i) begin
      auto_q  <= auto_d;
      width_q <= width_d;
      pos_a_q <= pos_a_d;
      pos_b_q <= pos_b_d;
      ptr_a_q <= ptr_a_d;
      ptr_b_q <= ptr_b_d;
    end
  end

  assign res_o.read_data       = rd;
  assign res_o.fetch_address_a = ptr_a_d;
  assign res_o.fetch_address_b = ptr_b_d;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_a_q <= PosLimit && pos_b_q <= PosLimit)
    else $error("bit position above limit");

  a_manual_read_keeps_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i && !auto_q && (req_i.opcode == OP_READ_LO || req_i.opcode == OP_READ_HI)
    |=> $stable(ptr_a_q) && $stable(ptr_b_q) && $stable(pos_a_q) && $stable(pos_b_q))
    else $error("read without auto-advance changed state");

  a_lo_read_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i && req_i.opcode == OP_READ_LO
    |=> $stable(ptr_b_q) && (ptr_a_q == $past(ptr_a_q) || ptr_a_q == $past(ptr_a_q) + PtrStep))
    else $error("low read moved pointer wrongly");

endmodule

FILE: design/variable_length_bit_reader.sv
// top level: request register, step logic and result register
//
//  channel | dir | payload                                        | handshake
//  req_i   | in  | opcode, write_data, memory_word                | valid/ready
//  res_o   | out | read_data, fetch_address_a, fetch_address_b    | valid/ready
//
// one request per cycle sustained unless a waiting result is stalled by res_o.ready low
// the request register feeds the step logic, whose output lands in the result register
// state commits when a request moves into the result register
// reset (rst_ni low) clears width, flag, positions and pointers, and empties both stages
// a stalled result holds both stages; req_i.ready drops only when both are full
module variable_length_bit_reader (
  input  logic      clk_i,
  input  logic      rst_ni,
  vlbr_req_if.sink   req_i,
  vlbr_res_if.source res_o
);
  import vlbr_pkg::*;

  logic stage_vld_q, stage_vld_d;
  req_t stage_q;
  logic out_vld_q, out_vld_d;
  res_t out_q;
  res_t step_res;
  logic advance;
  logic take;

  assign advance     = stage_vld_q && (!out_vld_q || res_o.ready);
  assign req_i.ready = !stage_vld_q || advance;
  assign take        = req_i.valid && req_i.ready;

  assign stage_vld_d = take ? 1'b1 : (advance ? 1'b0 : stage_vld_q);
  assign out_vld_d   = advance ? 1'b1 : (res_o.ready ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_vld_q <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      stage_vld_q <= stage_vld_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      stage_q.opcode      <= req_i.opcode;
      stage_q.write_data  <= req_i.write_data;
      stage_q.memory_word <= req_i.memory_word;
    end
    if (advance) begin
      out_q <= step_res;
    end
  end

  vlbr_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (advance),
    .req_i    (stage_q),
    .res_o    (step_res)
  );

  assign res_o.valid           = out_vld_q;
  assign res_o.read_data       = out_q.read_data;
  assign res_o.fetch_address_a = out_q.fetch_address_a;
  assign res_o.fetch_address_b = out_q.fetch_address_b;

  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> req_i.ready)
    else $error("request refused with empty result register");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_vld_q && !out_vld_q |=> out_vld_q)
    else $error("pending request not moved to result register");

  a_stall_holds_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_vld_q && out_vld_q && !res_o.ready |=> stage_vld_q && $stable(stage_q))
    else $error("request register changed during stall");

endmodule
